### hdl/mtes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_pkg
// Types and fixed constants shared by the MIDI track event splitter files.
// ----------------------------------------------------------------------------
package mtes_pkg;

   // result outcome codes
   localparam logic [1:0] OUTCOME_DONE  = 2'd0;
   localparam logic [1:0] OUTCOME_BAD   = 2'd1;
   localparam logic [1:0] OUTCOME_TRUNC = 2'd2;

   // status and meta codes, plus the track index limit
   localparam logic [7:0] META_STATUS   = 8'hFF;
   localparam logic [3:0] SYSTEM_NIBBLE = 4'hF;
   localparam logic [3:0] PROG_NIBBLE   = 4'hC;
   localparam logic [3:0] PRESS_NIBBLE  = 4'hD;
   localparam logic [7:0] META_EOT      = 8'h2F;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] TRACK_LIMIT   = 8'hFF;

   typedef struct packed {
      logic [7:0]  track_number;
      logic [31:0] event_ticks;
      logic [7:0]  status_byte;
      logic        used_running;
      logic [31:0] event_offset;
      logic [31:0] event_length;
      logic        is_tempo;
      logic [31:0] tempo_value;
      logic [1:0]  outcome;
   } rsp_type;

endpackage

### hdl/mtes_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_req_if / mtes_rsp_if
// Valid/ready channels for the raw byte stream and for parsed event results.
// ----------------------------------------------------------------------------
interface mtes_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface mtes_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  track_number;
   logic [31:0] event_ticks;
   logic [7:0]  status_byte;
   logic        used_running;
   logic [31:0] event_offset;
   logic [31:0] event_length;
   logic        is_tempo;
   logic [31:0] tempo_value;
   logic [1:0]  outcome;

   modport source (output valid, output track_number, output event_ticks,
                   output status_byte, output used_running, output event_offset,
                   output event_length, output is_tempo, output tempo_value,
                   output outcome, input ready);
   modport sink (input valid, input track_number, input event_ticks,
                 input status_byte, input used_running, input event_offset,
                 input event_length, input is_tempo, input tempo_value,
                 input outcome, output ready);
endinterface

### hdl/mtes_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_parser
// Track parser state; one accepted byte updates it and may produce one event.
// ----------------------------------------------------------------------------
module mtes_parser #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  logic [7:0]        step_byte,
   output logic              res_valid,
   output mtes_pkg::rsp_type res
);
   import mtes_pkg::*;

   localparam int NB_W = $clog2(MAX_VLQ_BYTES + 1);
   localparam logic [NB_W:0] VLQ_LIMIT = (NB_W + 1)'(MAX_VLQ_BYTES);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_DELTA  = 3'd1;
   localparam logic [2:0] PH_STATUS = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_META   = 3'd4;
   localparam logic [2:0] PH_LEN    = 3'd5;
   localparam logic [2:0] PH_HALT   = 3'd6;

   logic [2:0]      phase_ff, phase_in;
   logic [1:0]      header_ff, header_in;
   logic [31:0]     bytes_left_ff, bytes_left_in;
   logic [31:0]     position_ff, position_in;
   logic [31:0]     ticks_ff, ticks_in;
   logic [31:0]     accum_ff, accum_in;
   logic [NB_W-1:0] nbytes_ff, nbytes_in;
   logic [7:0]      last_chan_ff, last_chan_in;
   logic [7:0]      status_ff, status_in;
   logic [31:0]     payload_ff, payload_in;
   logic [31:0]     start_ff, start_in;
   logic            running_ff, running_in;
   logic [7:0]      meta_ff, meta_in;
   logic [31:0]     tempo_ff, tempo_in;
   logic [7:0]      track_ff, track_in;

   logic [31:0] acc_vlq;
   logic [31:0] hdr_acc;
   logic [NB_W:0] nb_inc;
   logic        vlq_end;
   logic [7:0]  eff_status;
   logic [1:0]  need;
   logic [31:0] payload_dec;
   logic        bad;
   logic        done;
   logic        emit_en;
   logic [1:0]  outcome_sel;
   logic        wrap_track;
   logic        tempo_hit;
   logic        eot_hit;

   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      bytes_left_in = bytes_left_ff;
      position_in  = position_ff;
      ticks_in     = ticks_ff;
      accum_in     = accum_ff;
      nbytes_in    = nbytes_ff;
      last_chan_in = last_chan_ff;
      status_in    = status_ff;
      payload_in   = payload_ff;
      start_in     = start_ff;
      running_in   = running_ff;
      meta_in      = meta_ff;
      tempo_in     = tempo_ff;
      track_in     = track_ff;
      bad          = 1'b0;
      done         = 1'b0;
      emit_en      = 1'b0;
      outcome_sel  = OUTCOME_DONE;
      wrap_track   = 1'b0;

      acc_vlq     = {accum_ff[24:0], step_byte[6:0]};
      hdr_acc     = {accum_ff[23:0], step_byte};
      nb_inc      = {1'b0, nbytes_ff} + (NB_W + 1)'(1);
      vlq_end     = !step_byte[7] || (nb_inc >= VLQ_LIMIT);
      eff_status  = step_byte[7] ? step_byte : last_chan_ff;
      need        = (eff_status[7:4] inside {PROG_NIBBLE, PRESS_NIBBLE}) ? 2'd1 : 2'd2;
      need        = need - {1'b0, !step_byte[7]};
      payload_dec = payload_ff - 32'd1;

      if (step_valid && (phase_ff != PH_HALT)) begin
         if (phase_ff == PH_HEADER) begin
            accum_in  = hdr_acc;
            header_in = header_ff + 2'd1;
            if (header_ff == 2'd3) begin
               bytes_left_in = hdr_acc;
               header_in     = 2'd0;
               accum_in      = 32'd0;
               nbytes_in     = '0;
               position_in   = 32'd0;
               ticks_in      = 32'd0;
               last_chan_in  = 8'd0;
               if (hdr_acc == 32'd0) begin
                  wrap_track = 1'b1;
               end else begin
                  phase_in = PH_DELTA;
               end
            end
         end else begin
            position_in   = position_ff + 32'd1;
            bytes_left_in = bytes_left_ff - 32'd1;
            case (phase_ff)
               PH_DELTA: begin
                  accum_in  = acc_vlq;
                  nbytes_in = nb_inc[NB_W-1:0];
                  if (vlq_end) begin
                     ticks_in   = ticks_ff + acc_vlq;
                     accum_in   = 32'd0;
                     nbytes_in  = '0;
                     start_in   = position_in;
                     status_in  = 8'd0;
                     running_in = 1'b0;
                     meta_in    = 8'd0;
                     tempo_in   = 32'd0;
                     phase_in   = PH_STATUS;
                  end
               end
               PH_STATUS: begin
                  status_in  = eff_status;
                  running_in = !step_byte[7];
                  if (step_byte[7] && (step_byte[7:4] != SYSTEM_NIBBLE)) begin
                     last_chan_in = step_byte;
                  end
                  if (!eff_status[7]) begin
                     bad = 1'b1;
                  end else if (eff_status == META_STATUS) begin
                     phase_in = PH_META;
                  end else if (eff_status[7:4] == SYSTEM_NIBBLE) begin
                     accum_in  = 32'd0;
                     nbytes_in = '0;
                     phase_in  = PH_LEN;
                  end else begin
                     payload_in = {30'd0, need};
                     if (need == 2'd0) begin
                        done = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_META: begin
                  meta_in   = step_byte;
                  accum_in  = 32'd0;
                  nbytes_in = '0;
                  phase_in  = PH_LEN;
               end
               PH_LEN: begin
                  accum_in  = acc_vlq;
                  nbytes_in = nb_inc[NB_W-1:0];
                  if (vlq_end) begin
                     payload_in = acc_vlq;
                     accum_in   = 32'd0;
                     nbytes_in  = '0;
                     if (acc_vlq == 32'd0) begin
                        done = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  if ((status_ff == META_STATUS) && (meta_ff == META_TEMPO)) begin
                     tempo_in = {tempo_ff[23:0], step_byte};
                  end
                  payload_in = payload_dec;
                  if (payload_dec == 32'd0) begin
                     done = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            if (bad) begin
               emit_en     = 1'b1;
               outcome_sel = OUTCOME_BAD;
               phase_in    = PH_HALT;
            end else if (done) begin
               emit_en    = 1'b1;
               phase_in   = PH_DELTA;
               wrap_track = (bytes_left_in == 32'd0);
            end else if (bytes_left_in == 32'd0) begin
               // track ran out mid event; clear event fields if still in the delta
               if (phase_in == PH_DELTA) begin
                  start_in   = position_in;
                  status_in  = 8'd0;
                  running_in = 1'b0;
                  meta_in    = 8'd0;
                  tempo_in   = 32'd0;
               end
               emit_en     = 1'b1;
               outcome_sel = OUTCOME_TRUNC;
               wrap_track  = 1'b1;
            end
         end
      end

      tempo_hit = (status_in == META_STATUS) && (meta_in == META_TEMPO);
      eot_hit   = (status_in == META_STATUS) && (meta_in == META_EOT);

      res_valid = emit_en && !(eot_hit && (outcome_sel != OUTCOME_BAD));
      res.track_number = track_ff;
      res.event_ticks  = ticks_in;
      res.status_byte  = status_in;
      res.used_running = running_in;
      res.event_offset = start_in;
      res.event_length = position_in - start_in;
      res.is_tempo     = tempo_hit;
      res.tempo_value  = tempo_hit ? tempo_in : 32'd0;
      res.outcome      = outcome_sel;

      if (wrap_track) begin
         if (track_ff != TRACK_LIMIT) begin
            track_in = track_ff + 8'd1;
         end
         phase_in  = PH_HEADER;
         header_in = 2'd0;
         accum_in  = 32'd0;
         nbytes_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         header_ff     <= 2'd0;
         bytes_left_ff <= 32'd0;
         position_ff   <= 32'd0;
         ticks_ff      <= 32'd0;
         accum_ff      <= 32'd0;
         nbytes_ff     <= '0;
         last_chan_ff  <= 8'd0;
         status_ff     <= 8'd0;
         payload_ff    <= 32'd0;
         start_ff      <= 32'd0;
         running_ff    <= 1'b0;
         meta_ff       <= 8'd0;
         tempo_ff      <= 32'd0;
         track_ff      <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         header_ff     <= header_in;
         bytes_left_ff <= bytes_left_in;
         position_ff   <= position_in;
         ticks_ff      <= ticks_in;
         accum_ff      <= accum_in;
         nbytes_ff     <= nbytes_in;
         last_chan_ff  <= last_chan_in;
         status_ff     <= status_in;
         payload_ff    <= payload_in;
         start_ff      <= start_in;
         running_ff    <= running_in;
         meta_ff       <= meta_in;
         tempo_ff      <= tempo_in;
         track_ff      <= track_in;
      end
   end

`ifndef ASSERT_OFF
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("parser left halt without reset");

   a_bad_halts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.outcome == OUTCOME_BAD)) |=> (phase_ff == PH_HALT))
      else $error("invalid status did not halt parser");

   a_trunc_wraps: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.outcome == OUTCOME_TRUNC))
      |=> ((phase_ff == PH_HEADER) && (bytes_left_ff == 32'd0)))
      else $error("truncated event did not move to next track header");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HEADER) |-> (header_ff == 2'd0))
      else $error("header byte count nonzero outside header");
`endif

endmodule

### hdl/mtes_rsp_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_rsp_buf
// Two-entry result buffer; keeps the byte side moving while a result waits.
// ----------------------------------------------------------------------------
module mtes_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtes_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output mtes_pkg::rsp_type out_data
);
   import mtes_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("result pushed into full buffer");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("buffer count did not drop on pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd0) || (count_ff == 2'd2)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("buffer pointers disagree with count");
`endif

endmodule

### hdl/midi_track_event_splitter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_splitter_core
// Splits a stream of length-prefixed MIDI tracks into timed, classified events.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    data_byte: next raw track byte
//   rsp_chan  out   valid/ready    one record per event, end-of-track excepted
//
// One byte is accepted per cycle unless stalled; an event record is buffered
// in the cycle after the byte that ends it. A two-entry result buffer sets
// the stall point: req_chan.ready drops only while both entries hold
// unclaimed records. Reset is synchronous; all parser state clears in the
// reset cycle. After an invalid status the block still takes and drops bytes.
// ----------------------------------------------------------------------------
module midi_track_event_splitter_core #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   mtes_req_if.sink   req_chan,
   mtes_rsp_if.source rsp_chan
);
   import mtes_pkg::*;

   logic    accept;
   logic    res_valid;
   rsp_type res;
   logic    space;
   logic    out_valid;
   rsp_type out_data;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   mtes_parser #(
      .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_valid(accept),
      .step_byte (req_chan.data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   mtes_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res),
      .space    (space),
      .out_valid(out_valid),
      .out_ready(rsp_chan.ready),
      .out_data (out_data)
   );

   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.track_number = out_data.track_number;
   assign rsp_chan.event_ticks  = out_data.event_ticks;
   assign rsp_chan.status_byte  = out_data.status_byte;
   assign rsp_chan.used_running = out_data.used_running;
   assign rsp_chan.event_offset = out_data.event_offset;
   assign rsp_chan.event_length = out_data.event_length;
   assign rsp_chan.is_tempo     = out_data.is_tempo;
   assign rsp_chan.tempo_value  = out_data.tempo_value;
   assign rsp_chan.outcome      = out_data.outcome;

endmodule

### dv/midi_track_event_splitter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_splitter_core_tb
// Feeds length-prefixed MIDI tracks into the splitter one byte at a time and
// checks every event record against a cycle-free parser model kept here or,
// where a row gives one, a hand-made record. A short table of hand-made tracks
// runs first, then tracks of random but mostly well-formed events, and an
// invalid running status that halts the block at the very end.
// ----------------------------------------------------------------------------
module midi_track_event_splitter_core_tb;
   import mtes_pkg::*;

   localparam int VLQ_LIMIT   = 4;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_HALF = 245;
   // header of a 3-byte track, zero delta, data byte with no status, then junk
   localparam logic [63:0] HALT_TAIL = 64'h00000003_0040_55FF;

   localparam logic [2:0] AT_HEADER = 3'd0;
   localparam logic [2:0] AT_DELTA  = 3'd1;
   localparam logic [2:0] AT_STATUS = 3'd2;
   localparam logic [2:0] AT_DATA   = 3'd3;
   localparam logic [2:0] AT_META   = 3'd4;
   localparam logic [2:0] AT_LENGTH = 3'd5;
   localparam logic [2:0] HALTED    = 3'd6;

   localparam rsp_type NO_EVENT = '0;

   typedef struct {
      logic [7:0] data;
      bit         typed;
      rsp_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   mtes_req_if req_if ();
   mtes_rsp_if rsp_if ();

   midi_track_event_splitter_core #(.MAX_VLQ_BYTES(VLQ_LIMIT)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   // parser model state
   logic [2:0]  phase;
   int          hdr_cnt;
   logic [31:0] trk_left;
   logic [31:0] trk_pos;
   logic [31:0] tick_sum;
   logic [31:0] vlq_acc;
   int          vlq_len;
   logic [7:0]  chan_status;
   logic [7:0]  cur_status;
   logic [31:0] data_left;
   logic [31:0] ev_start;
   logic        ev_running;
   logic [7:0]  meta_type;
   logic [31:0] tempo_acc;
   logic [7:0]  trk_count;

   rsp_type      pending_events [$];
   stim_row_type directed_rows [$];
   logic [7:0]   eot_script [$];
   logic [31:0]  plan_len;
   bit           heavy_ticks;
   bit           src_idle_on;
   bit           sink_idle_on;
   int           errors;
   int           stall_cycles = 0;

   function automatic rsp_type event_rec(logic [7:0] trk, logic [31:0] tk, logic [7:0] st,
                                         logic run, logic [31:0] off, logic [31:0] len,
                                         logic tflag, logic [31:0] tval, logic [1:0] oc);
      event_rec = {trk, tk, st, run, off, len, tflag, tval, oc};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic void open_next_track();
      if (trk_count < TRACK_LIMIT)
         trk_count++;
      phase   = AT_HEADER;
      hdr_cnt = 0;
      vlq_acc = '0;
      vlq_len = 0;
   endfunction

   function automatic bit vlq_add(input logic [7:0] b);
      vlq_acc = {vlq_acc[24:0], b[6:0]};
      vlq_len++;
      return !b[7] || (vlq_len >= VLQ_LIMIT);
   endfunction

   function automatic bit make_event(input logic [1:0] oc, output rsp_type ev);
      logic tempo;
      tempo = (cur_status == META_STATUS) && (meta_type == META_TEMPO);
      ev = NO_EVENT;
      // end-of-track meta never produces a record unless it is the error case
      if (cur_status == META_STATUS && meta_type == META_EOT && oc != OUTCOME_BAD)
         return 1'b0;
      ev = event_rec(trk_count, tick_sum, cur_status, ev_running, ev_start,
                     trk_pos - ev_start, tempo, tempo ? tempo_acc : 32'd0, oc);
      return 1'b1;
   endfunction

   function automatic void clear_event();
      cur_status = '0;
      ev_running = 1'b0;
      meta_type  = '0;
      tempo_acc  = '0;
   endfunction

   task automatic parse_byte(input logic [7:0] b, output bit got, output rsp_type ev);
      bit          done;
      bit          bad;
      logic [31:0] need;
      done = 1'b0;
      bad  = 1'b0;
      got  = 1'b0;
      ev   = NO_EVENT;
      if (phase == HALTED)
         return;
      if (phase == AT_HEADER) begin
         vlq_acc = {vlq_acc[23:0], b};
         hdr_cnt++;
         if (hdr_cnt >= 4) begin
            trk_left    = vlq_acc;
            hdr_cnt     = 0;
            vlq_acc     = '0;
            vlq_len     = 0;
            trk_pos     = '0;
            tick_sum    = '0;
            chan_status = '0;
            if (trk_left == 0)
               open_next_track();
            else
               phase = AT_DELTA;
         end
         return;
      end
      trk_pos++;
      trk_left--;
      case (phase)
         AT_DELTA: begin
            if (vlq_add(b)) begin
               tick_sum += vlq_acc;
               vlq_acc  = '0;
               vlq_len  = 0;
               ev_start = trk_pos;
               clear_event();
               phase = AT_STATUS;
            end
         end
         AT_STATUS: begin
            if (b[7]) begin
               cur_status = b;
               ev_running = 1'b0;
               if (b[7:4] != SYSTEM_NIBBLE)
                  chan_status = b;
            end else begin
               cur_status = chan_status;
               ev_running = 1'b1;
            end
            if (!cur_status[7]) begin
               bad = 1'b1;
            end else if (cur_status == META_STATUS) begin
               phase = AT_META;
            end else if (cur_status[7:4] == SYSTEM_NIBBLE) begin
               vlq_acc = '0;
               vlq_len = 0;
               phase   = AT_LENGTH;
            end else begin
               need = (cur_status[7:4] inside {PROG_NIBBLE, PRESS_NIBBLE}) ? 32'd1 : 32'd2;
               if (ev_running)
                  need--;
               data_left = need;
               if (need == 0)
                  done = 1'b1;
               else
                  phase = AT_DATA;
            end
         end
         AT_META: begin
            meta_type = b;
            vlq_acc   = '0;
            vlq_len   = 0;
            phase     = AT_LENGTH;
         end
         AT_LENGTH: begin
            if (vlq_add(b)) begin
               data_left = vlq_acc;
               vlq_acc   = '0;
               vlq_len   = 0;
               if (data_left == 0)
                  done = 1'b1;
               else
                  phase = AT_DATA;
            end
         end
         default: begin
            if (cur_status == META_STATUS && meta_type == META_TEMPO)
               tempo_acc = {tempo_acc[23:0], b};
            data_left--;
            if (data_left == 0)
               done = 1'b1;
         end
      endcase
      if (bad) begin
         got   = make_event(OUTCOME_BAD, ev);
         phase = HALTED;
      end else if (done) begin
         got   = make_event(OUTCOME_DONE, ev);
         phase = AT_DELTA;
         if (trk_left == 0)
            open_next_track();
      end else if (trk_left == 0) begin
         // track ran out inside the delta: no event content yet
         if (phase == AT_DELTA) begin
            ev_start = trk_pos;
            clear_event();
         end
         got = make_event(OUTCOME_TRUNC, ev);
         open_next_track();
      end
   endtask

   // choose the next stream byte from where the parser model stands
   function automatic logic [7:0] pick_byte();
      int         r;
      logic [7:0] b;
      if (eot_script.size() != 0)
         return eot_script.pop_front();
      r = $urandom_range(0, 99);
      case (phase)
         AT_HEADER: begin
            if (hdr_cnt == 0) begin
               if (r < 8)
                  plan_len = '0;
               else if (r < 85)
                  plan_len = $urandom_range(1, 40);
               else
                  plan_len = $urandom_range(41, 120);
               heavy_ticks = ($urandom_range(0, 99) < 20);
            end
            return plan_len[31 - 8 * hdr_cnt -: 8];
         end
         AT_DELTA: begin
            if (vlq_len == 0 && trk_left == 4 && r < 50) begin
               eot_script = '{META_STATUS, META_EOT, 8'h00};
               return 8'h00;
            end
            if (heavy_ticks && r < 85)
               b = 8'hFF;
            else if (r < 35)
               b = $urandom_range(8'h80, 8'hFF);
            else if (r < 60)
               b = 8'h00;
            else
               b = $urandom_range(8'h00, 8'h7F);
         end
         AT_STATUS: begin
            if (chan_status != 0 && r < 30)
               b = $urandom_range(8'h00, 8'h7F);
            else if (r < 80)
               b = $urandom_range(8'h80, 8'hEF);
            else if (r < 92)
               b = META_STATUS;
            else
               b = $urandom_range(8'hF0, 8'hFE);
         end
         AT_META: begin
            if (r < 30)
               b = META_TEMPO;
            else if (r < 40)
               b = META_EOT;
            else
               b = $urandom_range(8'h00, 8'hFF);
         end
         AT_LENGTH: begin
            if (cur_status == META_STATUS && meta_type == META_TEMPO && vlq_len == 0 && r < 50)
               b = 8'd3;
            else if (r < 70)
               b = $urandom_range(0, 6);
            else if (r < 88)
               b = $urandom_range(8'h00, 8'h7F);
            else
               b = $urandom_range(8'h00, 8'hFF);
         end
         default: begin
            if (r < 85)
               b = $urandom_range(8'h00, 8'h7F);
            else
               b = $urandom_range(8'h00, 8'hFF);
         end
      endcase
      if ($urandom_range(0, 99) < 3)
         b = $urandom_range(8'h00, 8'hFF);
      // a data byte with no channel status would halt the block: hold that for the end
      if (phase == AT_STATUS && !b[7] && chan_status == 0)
         b[7] = 1'b1;
      return b;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input bit typed, input rsp_type want);
      bit      got;
      rsp_type ev;
      while (src_idle_on && $urandom_range(0, 99) < 16) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      parse_byte(b, got, ev);
      if (typed)
         pending_events.push_back(want);
      else if (got)
         pending_events.push_back(ev);
      @(negedge clock);
   endtask

   task automatic row(input logic [7:0] d, input bit typed, input rsp_type want);
      stim_row_type r;
      r.data  = d;
      r.typed = typed;
      r.want  = want;
      directed_rows.push_back(r);
   endtask

   task automatic check_event(input rsp_type got);
      rsp_type want;
      if (pending_events.size() == 0) begin
         report_mismatch("event with nothing pending, event_ticks", got.event_ticks, '0);
         return;
      end
      want = pending_events.pop_front();
      if (got.track_number !== want.track_number)
         report_mismatch("track_number", got.track_number, want.track_number);
      if (got.event_ticks !== want.event_ticks)
         report_mismatch("event_ticks", got.event_ticks, want.event_ticks);
      if (got.status_byte !== want.status_byte)
         report_mismatch("status_byte", got.status_byte, want.status_byte);
      if (got.used_running !== want.used_running)
         report_mismatch("used_running", got.used_running, want.used_running);
      if (got.event_offset !== want.event_offset)
         report_mismatch("event_offset", got.event_offset, want.event_offset);
      if (got.event_length !== want.event_length)
         report_mismatch("event_length", got.event_length, want.event_length);
      if (got.is_tempo !== want.is_tempo)
         report_mismatch("is_tempo", got.is_tempo, want.is_tempo);
      if (got.tempo_value !== want.tempo_value)
         report_mismatch("tempo_value", got.tempo_value, want.tempo_value);
      if (got.outcome !== want.outcome)
         report_mismatch("outcome", got.outcome, want.outcome);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         check_event(event_rec(rsp_if.track_number, rsp_if.event_ticks, rsp_if.status_byte,
                               rsp_if.used_running, rsp_if.event_offset,
                               rsp_if.event_length, rsp_if.is_tempo, rsp_if.tempo_value,
                               rsp_if.outcome));
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= !(sink_idle_on && $urandom_range(0, 99) < 16);
      end
   end

   initial begin
      int n;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      errors           = 0;
      src_idle_on      = 1'b1;
      sink_idle_on     = 1'b1;
      plan_len         = '0;
      heavy_ticks      = 1'b0;
      phase            = AT_HEADER;
      hdr_cnt          = 0;
      trk_left         = '0;
      trk_pos          = '0;
      tick_sum         = '0;
      vlq_acc          = '0;
      vlq_len          = 0;
      chan_status      = '0;
      cur_status       = '0;
      data_left        = '0;
      ev_start         = '0;
      ev_running       = 1'b0;
      meta_type        = '0;
      tempo_acc        = '0;
      trk_count        = '0;

      // empty track: only bumps the track index
      row(8'h00, 0, NO_EVENT); row(8'h00, 0, NO_EVENT);
      row(8'h00, 0, NO_EVENT); row(8'h00, 0, NO_EVENT);
      // 17-byte track
      row(8'h00, 0, NO_EVENT); row(8'h00, 0, NO_EVENT);
      row(8'h00, 0, NO_EVENT); row(8'h11, 0, NO_EVENT);
      // overlong delta stops after four bytes, then a program change
      row(8'hFF, 0, NO_EVENT); row(8'hFF, 0, NO_EVENT);
      row(8'hFF, 0, NO_EVENT); row(8'hFF, 0, NO_EVENT);
      row(8'hC0, 0, NO_EVENT);
      row(8'h05, 1, event_rec(8'd1, 32'h0FFFFFFF, 8'hC0, 1'b0, 32'd4, 32'd2,
                              1'b0, 32'd0, OUTCOME_DONE));
      // running program change needs no further data
      row(8'h00, 0, NO_EVENT);
      row(8'h7F, 1, event_rec(8'd1, 32'h0FFFFFFF, 8'hC0, 1'b1, 32'd7, 32'd1,
                              1'b0, 32'd0, OUTCOME_DONE));
      // one-byte tempo meta
      row(8'h00, 0, NO_EVENT); row(META_STATUS, 0, NO_EVENT);
      row(META_TEMPO, 0, NO_EVENT); row(8'h01, 0, NO_EVENT);
      row(8'hAB, 1, event_rec(8'd1, 32'h0FFFFFFF, META_STATUS, 1'b0, 32'd9, 32'd4,
                              1'b1, 32'h000000AB, OUTCOME_DONE));
      // end-of-track meta closes the track without a record
      row(8'h00, 0, NO_EVENT); row(META_STATUS, 0, NO_EVENT);
      row(META_EOT, 0, NO_EVENT); row(8'h00, 0, NO_EVENT);
      // one-byte track ends inside the delta
      row(8'h00, 0, NO_EVENT); row(8'h00, 0, NO_EVENT);
      row(8'h00, 0, NO_EVENT); row(8'h01, 0, NO_EVENT);
      row(8'h81, 1, event_rec(8'd2, 32'd0, 8'h00, 1'b0, 32'd1, 32'd0,
                              1'b0, 32'd0, OUTCOME_TRUNC));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

      n = 0;
      while (n < RANDOM_HALF || phase != AT_HEADER || hdr_cnt != 0) begin
         send_byte(pick_byte(), 0, NO_EVENT);
         n++;
      end

      // drain before going on
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_events.size() != 0)
         @(negedge clock);

      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      n = 0;
      while (n < RANDOM_HALF || phase != AT_HEADER || hdr_cnt != 0) begin
         if (n == 150) begin
            src_idle_on  = 1'b1;
            sink_idle_on = 1'b1;
         end
         send_byte(pick_byte(), 0, NO_EVENT);
         n++;
      end

      // invalid running status halts the parser; later bytes are dropped
      for (int i = 7; i >= 0; i--)
         send_byte(HALT_TAIL[8 * i +: 8], 0, NO_EVENT);
      req_if.valid <= 1'b0;

      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_events.size() != 0)
         report_mismatch("events never delivered", pending_events.size(), '0);

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### files.f
hdl/mtes_pkg.sv
hdl/mtes_if.sv
hdl/mtes_parser.sv
hdl/mtes_rsp_buf.sv
hdl/midi_track_event_splitter_core.sv
dv/midi_track_event_splitter_core_tb.sv
